[src/piecewise_mean_downsampler_core_assert.svh]
// Assertion macros for the piecewise mean downsampler.
`ifndef PIECEWISE_MEAN_DOWNSAMPLER_CORE_ASSERT_SVH
`define PIECEWISE_MEAN_DOWNSAMPLER_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define PMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define PMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pmd_pkg.sv]
// Shared constants and types of the piecewise mean downsampler.
package pmd_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;
  localparam int unsigned LENGTH_WIDTH_DEF  = 16;
  localparam int unsigned WINDOW_WIDTH      = 12;
  localparam int unsigned MEAN_WIDTH        = 24;
  localparam int unsigned FRAC_BITS         = 8;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned SERIES_LENGTH_RST = 256;
  localparam int unsigned WINDOW_COUNT_RST  = 16;

  typedef enum logic {
    CFG_SERIES_LENGTH = 1'b0,
    CFG_WINDOW_COUNT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic [WINDOW_WIDTH-1:0] index;
    logic                    last;
  } win_tag_t;

  typedef struct packed {
    logic [WINDOW_WIDTH-1:0] windows;
    logic                    room_empty;
  } front_stat_t;

endpackage

[src/pmd_fifo.sv]
// Short register queue between the accumulate front and the divide back end.
module pmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pmd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/pmd_front.sv]
// Front end: configuration, window bookkeeping and weighted accumulation.
module pmd_front #(
  parameter  int unsigned SAMPLE_WIDTH = pmd_pkg::SAMPLE_WIDTH_DEF,
  parameter  int unsigned LENGTH_WIDTH = pmd_pkg::LENGTH_WIDTH_DEF,
  localparam int unsigned CFG_WIDTH    = (LENGTH_WIDTH > pmd_pkg::WINDOW_WIDTH) ?
                                         LENGTH_WIDTH : pmd_pkg::WINDOW_WIDTH,
  localparam int unsigned SUM_W        = SAMPLE_WIDTH + LENGTH_WIDTH + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  pmd_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]        cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                        push_i,
  input  logic                        queue_full_i,
  output logic                        win_valid_o,
  output logic signed [SUM_W-1:0]     win_sum_o,
  output pmd_pkg::win_tag_t           win_tag_o,
  output logic [LENGTH_WIDTH-1:0]     series_len_o,
  output pmd_pkg::front_stat_t        stat_o
);

  localparam int unsigned WW     = pmd_pkg::WINDOW_WIDTH;
  localparam int unsigned CW     = CFG_WIDTH;
  localparam int unsigned PROD_W = SAMPLE_WIDTH + WW + 1;

  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic [WW-1:0]           wcnt_q, wcnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [LENGTH_WIDTH-1:0] room_q, room_d;
  logic [WW-1:0]           win_q, win_d;

  logic [LENGTH_WIDTH-1:0] n_eff;
  logic [WW-1:0]           wc_eff, w_eff;
  logic [CW-1:0]           n_c, w_c, room_c, take_c, rest_c, left_c, refill_c;
  logic                    accept, close, last;
  logic signed [PROD_W-1:0] prod_take, prod_left;
  logic signed [SUM_W-1:0] sum_acc;

  assign accept = push_i && !queue_full_i;

  always_comb begin
    n_eff    = (len_q == '0) ? LENGTH_WIDTH'(1) : len_q;
    wc_eff   = (wcnt_q == '0) ? WW'(1) : wcnt_q;
    n_c      = CW'(n_eff);
    w_c      = (CW'(wc_eff) > n_c) ? n_c : CW'(wc_eff);
    w_eff    = w_c[WW-1:0];
    room_c   = ((room_q == '0) || (CW'(room_q) > n_c)) ? n_c : CW'(room_q);
    take_c   = (w_c < room_c) ? w_c : room_c;
    rest_c   = room_c - take_c;
    left_c   = w_c - take_c;
    refill_c = n_c - left_c;
    close    = (rest_c == '0);
    last     = (win_q >= (w_eff - WW'(1)));
    prod_take = sample_i * $signed({1'b0, take_c[WW-1:0]});
    prod_left = sample_i * $signed({1'b0, left_c[WW-1:0]});
    sum_acc  = sum_q + SUM_W'(prod_take);
  end

  always_comb begin
    len_d  = len_q;
    wcnt_d = wcnt_q;
    sum_d  = sum_q;
    room_d = room_q;
    win_d  = win_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pmd_pkg::CFG_SERIES_LENGTH: len_d  = cfg_wdata_i[LENGTH_WIDTH-1:0];
        pmd_pkg::CFG_WINDOW_COUNT:  wcnt_d = cfg_wdata_i[WW-1:0];
        default: ;
      endcase
      sum_d  = '0;
      room_d = '0;
      win_d  = '0;
    end else if (accept) begin
      if (close) begin
        sum_d  = SUM_W'(prod_left);
        room_d = refill_c[LENGTH_WIDTH-1:0];
        win_d  = last ? '0 : win_q + WW'(1);
      end else begin
        sum_d  = sum_acc;
        room_d = rest_c[LENGTH_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LENGTH_WIDTH'(pmd_pkg::SERIES_LENGTH_RST);
      wcnt_q <= WW'(pmd_pkg::WINDOW_COUNT_RST);
      sum_q  <= '0;
      room_q <= '0;
      win_q  <= '0;
    end else begin
      len_q  <= len_d;
      wcnt_q <= wcnt_d;
      sum_q  <= sum_d;
      room_q <= room_d;
      win_q  <= win_d;
    end
  end

  assign win_valid_o       = accept && close;
  assign win_sum_o         = sum_acc;
  assign win_tag_o.index   = win_q;
  assign win_tag_o.last    = last;
  assign series_len_o      = n_eff;
  assign stat_o.windows    = w_eff;
  assign stat_o.room_empty = (room_q == '0);

endmodule

[src/pmd_divider.sv]
// Back end: bit-serial mean division, saturation and result register.
module pmd_divider #(
  parameter  int unsigned SAMPLE_WIDTH = pmd_pkg::SAMPLE_WIDTH_DEF,
  parameter  int unsigned LENGTH_WIDTH = pmd_pkg::LENGTH_WIDTH_DEF,
  localparam int unsigned SUM_W        = SAMPLE_WIDTH + LENGTH_WIDTH + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic signed [SUM_W-1:0]           in_sum_i,
  input  pmd_pkg::win_tag_t                 in_tag_i,
  input  logic [LENGTH_WIDTH-1:0]           divisor_i,
  output logic                              in_pop_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [pmd_pkg::MEAN_WIDTH-1:0] window_mean_o,
  output logic [pmd_pkg::WINDOW_WIDTH-1:0]  window_index_o,
  output logic                              last_window_o
);

  localparam int unsigned MW       = pmd_pkg::MEAN_WIDTH;
  localparam int unsigned FB       = pmd_pkg::FRAC_BITS;
  localparam int unsigned DVD_W    = SUM_W + FB;
  localparam int unsigned CNT_W    = $clog2(DVD_W);
  localparam longint unsigned MEAN_POS_LIM = (64'd1 << (MW - 1)) - 64'd1;
  localparam longint unsigned MEAN_NEG_LIM = (64'd1 << (MW - 1));

  pmd_pkg::div_state_e state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    ovalid_q, ovalid_d;
  logic [DVD_W-1:0]        dvd_q, dvd_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
  logic                    neg_q, neg_d;
  pmd_pkg::win_tag_t       tag_q, tag_d;
  logic signed [MW-1:0]    mean_q, mean_d;
  logic [pmd_pkg::WINDOW_WIDTH-1:0] idx_q, idx_d;
  logic                    lastw_q, lastw_d;

  logic [SUM_W-1:0]        mag;
  logic [LENGTH_WIDTH:0]   rem_sh, rem_diff;
  logic                    ge, load_out;
  logic signed [MW-1:0]    mean_c;

  always_comb begin
    mag      = in_sum_i[SUM_W-1] ? $unsigned(-in_sum_i) : $unsigned(in_sum_i);
    rem_sh   = {rem_q, dvd_q[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, divisor_i};
    ge       = (rem_sh >= {1'b0, divisor_i});
    if (neg_q) begin
      mean_c = (dvd_q > DVD_W'(MEAN_NEG_LIM)) ? {1'b1, {(MW - 1){1'b0}}} :
                                                -$signed(dvd_q[MW-1:0]);
    end else begin
      mean_c = (dvd_q > DVD_W'(MEAN_POS_LIM)) ? {1'b0, {(MW - 1){1'b1}}} :
                                                $signed(dvd_q[MW-1:0]);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    in_pop_o = 1'b0;
    load_out = 1'b0;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    tag_d    = tag_q;
    case (state_q)
      pmd_pkg::DIV_IDLE: begin
        if (in_valid_i) begin
          in_pop_o = 1'b1;
          dvd_d    = {mag, {FB{1'b0}}};
          rem_d    = '0;
          neg_d    = in_sum_i[SUM_W-1];
          tag_d    = in_tag_i;
          cnt_d    = '0;
          state_d  = pmd_pkg::DIV_RUN;
        end
      end
      pmd_pkg::DIV_RUN: begin
        dvd_d = {dvd_q[DVD_W-2:0], ge};
        rem_d = ge ? rem_diff[LENGTH_WIDTH-1:0] : rem_sh[LENGTH_WIDTH-1:0];
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          state_d = pmd_pkg::DIV_DONE;
        end
      end
      pmd_pkg::DIV_DONE: begin
        if (!ovalid_q || pop_i) begin
          load_out = 1'b1;
          state_d  = pmd_pkg::DIV_IDLE;
        end
      end
      default: state_d = pmd_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    mean_d   = mean_q;
    idx_d    = idx_q;
    lastw_d  = lastw_q;
    ovalid_d = ovalid_q;
    if (load_out) begin
      mean_d   = mean_c;
      idx_d    = tag_q.index;
      lastw_d  = tag_q.last;
      ovalid_d = 1'b1;
    end else if (pop_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pmd_pkg::DIV_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    tag_q   <= tag_d;
    mean_q  <= mean_d;
    idx_q   <= idx_d;
    lastw_q <= lastw_d;
  end

  assign empty_o        = !ovalid_q;
  assign window_mean_o  = mean_q;
  assign window_index_o = idx_q;
  assign last_window_o  = lastw_q;

endmodule

[src/piecewise_mean_downsampler_core.sv]
// Top level of the piecewise mean downsampler.
//
// Samples enter through a queue-style port: a sample transfers at a clock edge
// with push high and full low. Results leave the same way: the oldest window
// mean sits on window_mean_o, window_index_o and last_window_o while empty is
// low and transfers at an edge with pop high.
// The front end takes one sample per cycle while full is low: it splits the
// sample over the open window and the next one and updates the weighted sum
// in that cycle. Each closed window enters a four-entry queue. The back end
// divides the sum by the series length one quotient bit per cycle, in
// SAMPLE_WIDTH + LENGTH_WIDTH + 9 steps (41 at the defaults), and takes no
// new window until its result is in the result register. Samples keep
// flowing at one per cycle as long as windows close no faster than the back
// end finishes them; otherwise full rises while the queue is full. A stalled
// receiver holds the result register, then fills the queue, then raises full.
// Reset sets series_length to 256 and window_count to 16 and starts a new
// series; any register write also restarts the series.
`include "piecewise_mean_downsampler_core_assert.svh"

module piecewise_mean_downsampler_core #(
  parameter  int unsigned SAMPLE_WIDTH = pmd_pkg::SAMPLE_WIDTH_DEF,
  parameter  int unsigned LENGTH_WIDTH = pmd_pkg::LENGTH_WIDTH_DEF,
  localparam int unsigned CFG_WIDTH    = (LENGTH_WIDTH > pmd_pkg::WINDOW_WIDTH) ?
                                         LENGTH_WIDTH : pmd_pkg::WINDOW_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  pmd_pkg::cfg_reg_e                     cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]                  cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic                                  push,
  output logic                                  full,
  output logic signed [pmd_pkg::MEAN_WIDTH-1:0] window_mean_o,
  output logic [pmd_pkg::WINDOW_WIDTH-1:0]      window_index_o,
  output logic                                  last_window_o,
  output logic                                  empty,
  input  logic                                  pop
);

  localparam int unsigned SUM_W = SAMPLE_WIDTH + LENGTH_WIDTH + 1;
  localparam int unsigned REC_W = SUM_W + $bits(pmd_pkg::win_tag_t);
  localparam int unsigned WW    = pmd_pkg::WINDOW_WIDTH;

  logic                    win_valid;
  logic signed [SUM_W-1:0] win_sum;
  pmd_pkg::win_tag_t       win_tag;
  logic [LENGTH_WIDTH-1:0] series_len;
  pmd_pkg::front_stat_t    front_stat;

  logic [REC_W-1:0]        rec_wr, rec_rd;
  logic                    queue_full, queue_empty, queue_pop;

  pmd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_i),
    .push_i       (push),
    .queue_full_i (queue_full),
    .win_valid_o  (win_valid),
    .win_sum_o    (win_sum),
    .win_tag_o    (win_tag),
    .series_len_o (series_len),
    .stat_o       (front_stat)
  );

  assign rec_wr = {win_tag, win_sum};

  pmd_fifo #(
    .WIDTH (REC_W),
    .DEPTH (pmd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (win_valid),
    .data_i  (rec_wr),
    .pop_i   (queue_pop),
    .data_o  (rec_rd),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  pmd_divider #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_divider (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (!queue_empty),
    .in_sum_i       ($signed(rec_rd[SUM_W-1:0])),
    .in_tag_i       (pmd_pkg::win_tag_t'(rec_rd[REC_W-1:SUM_W])),
    .divisor_i      (series_len),
    .in_pop_o       (queue_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .window_mean_o  (window_mean_o),
    .window_index_o (window_index_o),
    .last_window_o  (last_window_o)
  );

  assign full = queue_full;

  `PMD_ASSERT_NEXT(a_room_refilled, clk_i, rst_ni, push && !full, !front_stat.room_empty, "window room empty after a sample transfer")
  `PMD_ASSERT_SAME(a_index_range, clk_i, rst_ni, !empty, window_index_o < front_stat.windows, "window index beyond window count")
  `PMD_ASSERT_SAME(a_last_index, clk_i, rst_ni, !empty && last_window_o, window_index_o == (front_stat.windows - WW'(1)), "last window flag on a window that is not the final one")

endmodule
